// File: sv/bclc_pkg.sv
package bclc_pkg;

  localparam int unsigned VALUE_W = 32;

  // register indexes
  localparam logic [2:0] REG_TO_BLOCKED    = 3'd0;
  localparam logic [2:0] REG_BLOCK_LOG     = 3'd1;
  localparam logic [2:0] REG_VALUE_MODE    = 3'd2;
  localparam logic [2:0] REG_BATCH_COUNT   = 3'd3;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;
  localparam logic [2:0] REG_PLANE_SIZE    = 3'd5;

  // value modes
  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_WIDEN  = 2'd1;
  localparam logic [1:0] MODE_NARROW = 2'd2;

  // binary16 -> binary32, exact
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [7:0]  ex;
    logic [9:0]  mm;
    logic [31:0] r;
    s  = {h[15], 31'd0};
    e  = h[14:10];
    m  = h[9:0];
    ex = 8'd0;
    mm = 10'd0;
    if (e == 5'd31) begin
      r = (m != 10'd0) ? (s | 32'h7FC0_0000 | {9'd0, m, 13'd0}) : (s | 32'h7F80_0000);
    end else if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = s;
      end else begin
        // normalize: find leading one among 10 bits
        for (int i = 0; i < 10; i++) begin
          if (m[i]) begin
            ex = 8'(103 + i);
            mm = 10'(m << (10 - i));
          end
        end
        r = s | {1'b0, ex, mm, 13'd0};
      end
    end else begin
      r = s | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // binary32 -> binary16, round to nearest even
  function automatic logic [31:0] narrow_single(input logic [31:0] x);
    logic [15:0] s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [15:0] h;
    logic [12:0] rem;
    logic [23:0] full;
    logic [4:0]  shift;
    logic [23:0] rem2;
    logic [23:0] half;
    logic [15:0] r;
    s     = {x[31], 15'd0};
    e     = x[30:23];
    m     = x[22:0];
    full  = {1'b1, m};
    shift = 5'd0;
    h     = 16'd0;
    rem   = 13'd0;
    rem2  = 24'd0;
    half  = 24'd0;
    if (e == 8'd255) begin
      r = (m != 23'd0) ? (s | 16'h7E00 | {6'd0, m[22:13]}) : (s | 16'h7C00);
    end else if (e >= 8'd143) begin
      r = s | 16'h7C00;
    end else if (e >= 8'd113) begin
      h   = {1'b0, 5'(e - 8'd112), m[22:13]};
      rem = m[12:0];
      if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 16'd1;
      r = s | h;
    end else if (e < 8'd102) begin
      r = s;
    end else begin
      // shift = 14 - (e - 112) = 126 - e, range 14..24
      shift = 5'(8'd126 - e);
      h     = 16'(full >> shift);
      rem2  = full & ((24'd1 << shift) - 24'd1);
      half  = 24'd1 << (shift - 5'd1);
      if (rem2 > half || (rem2 == half && h[0])) h = h + 16'd1;
      r = s | h;
    end
    return {16'd0, r};
  endfunction

endpackage

// File: sv/bclc_stream_if.sv
interface bclc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/bclc_cfg_if.sv
interface bclc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: sv/blocked_channel_layout_converter.sv
// Blocked channel layout converter.
// Streams one element per transfer through the loop nest batch / channel /
// plane and returns, per element, the source index, destination index,
// converted value, a padding flag and a last flag.
// Channels: in_if (value_in), out_if (result), cfg_if (register writes,
// index = register number). A register write restarts the tensor.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one element per cycle while results drain and no stride
// recompute is pending. Indices come from running bases and adders, so the
// per-cycle cost is one 40-bit add tree and the fp convert. After a register
// write, input is held off while the batch strides are recomputed.
// Reset: registers take their defaults (to plain->blocked, block of 8,
// copy, N=1, C=8, P=1); counters and bases are zero, output empty.
// Stall: the result register holds while out_if.ready is low; an element is
// taken when strides are settled and the register is empty or draining.
// Configuration must be written only when the block is idle.
module blocked_channel_layout_converter
  import bclc_pkg::*;
#(
  parameter int unsigned MAX_BATCH    = 1024,
  parameter int unsigned MAX_CHANNELS = 65536,
  parameter int unsigned MAX_PLANE    = 16777216,
  parameter int unsigned INDEX_BITS   = 40
) (
  input  logic clk_i,
  input  logic rst_ni,
  bclc_cfg_if.sink    cfg_if,
  bclc_stream_if.sink in_if,
  bclc_stream_if.source out_if
);
  localparam int unsigned BW = $clog2(MAX_BATCH + 1);
  localparam int unsigned CW = $clog2(MAX_CHANNELS + 8);
  localparam int unsigned PW = $clog2(MAX_PLANE + 1);
  localparam int unsigned IW = INDEX_BITS;

  typedef struct packed {
    logic [IW-1:0] source_index;
    logic [IW-1:0] dest_index;
    logic [31:0]   value_out;
    logic          is_padding;
    logic          is_last;
  } res_t;

  // configuration registers (effective, clamped values)
  logic          to_blk_q;
  logic          bl3_q;
  logic [1:0]    mode_q;
  logic [BW-1:0] n_q;
  logic [CW-1:0] c_q;
  logic [PW-1:0] p_q;

  // loop state
  logic [BW-1:0] b_q;
  logic [CW-1:0] ch_q;
  logic [PW-1:0] k_q;
  logic [IW-1:0] plain_base_q, blk_base_q;
  // running terms: ch*P and (ch>>bl)*P<<bl, plus k<<bl
  logic [IW-1:0] chp_q, blkp_q;
  // per-batch strides C*P and Cp*P
  logic [IW-1:0] cstr_q, cpstr_q;

  logic cfg_wr, in_acc;
  assign cfg_if.ready = 1'b1;
  assign cfg_wr = cfg_if.valid;

  function automatic logic [63:0] clampv(input logic [31:0] v, input logic [63:0] mx);
    logic [63:0] r;
    r = {32'd0, v};
    if (r == 64'd0) r = 64'd1;
    if (r > mx) r = mx;
    return r;
  endfunction

  logic [CW-1:0] cp;
  logic [CW-1:0] limit;
  always_comb begin
    cp    = bl3_q ? ((c_q + CW'(7)) & ~CW'(7)) : ((c_q + CW'(3)) & ~CW'(3));
    limit = to_blk_q ? cp : c_q;
  end

  // configuration writes; the strides are then recomputed by a registered multiply
  logic stride_dirty_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_blk_q <= 1'b1;
      bl3_q    <= 1'b1;
      mode_q   <= MODE_COPY;
      n_q      <= BW'(1);
      c_q      <= CW'(8);
      p_q      <= PW'(1);
      stride_dirty_q <= 1'b1;
    end else begin
      stride_dirty_q <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_if.index)
          REG_TO_BLOCKED:  to_blk_q <= cfg_if.wdata[0];
          REG_BLOCK_LOG:   bl3_q    <= (cfg_if.wdata[1:0] == 2'd3);
          REG_VALUE_MODE:  mode_q   <= cfg_if.wdata[1:0];
          REG_BATCH_COUNT:
            n_q <= BW'(clampv({21'd0, cfg_if.wdata[10:0]}, 64'(MAX_BATCH)));
          REG_CHANNEL_COUNT:
            c_q <= CW'(clampv({15'd0, cfg_if.wdata[16:0]}, 64'(MAX_CHANNELS)));
          REG_PLANE_SIZE:
            p_q <= PW'(clampv({7'd0, cfg_if.wdata[24:0]}, 64'(MAX_PLANE)));
          default: ;
        endcase
      end
    end
  end

  // batch strides (narrow multiplies, registered)
  logic [IW-1:0] cstr_d, cpstr_d;
  assign cstr_d  = IW'({32'd0, c_q} * {32'd0, p_q});
  assign cpstr_d = IW'({32'd0, cp} * {32'd0, p_q});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cstr_q  <= IW'(8);
      cpstr_q <= IW'(8);
    end else begin
      cstr_q  <= cstr_d;
      cpstr_q <= cpstr_d;
    end
  end

  // output register handshake
  logic out_v_q;
  res_t res_q, res_d;
  assign in_if.ready  = (!out_v_q || out_if.ready) && !stride_dirty_q;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_if.valid = out_v_q;
  assign out_if.data  = res_q;

  // index and flag logic
  logic          pad, lastp, k_end, ch_end, b_end;
  logic [IW-1:0] kbl, plain_idx, blk_idx, lowch;
  logic [31:0]   conv;
  always_comb begin
    pad    = to_blk_q && (ch_q >= c_q);
    k_end  = (k_q + PW'(1)) >= p_q;
    ch_end = (ch_q + CW'(1)) >= limit;
    b_end  = (b_q + BW'(1)) >= n_q;
    lastp  = k_end && ch_end && b_end;
    kbl    = bl3_q ? IW'({k_q, 3'd0}) : IW'({k_q, 2'd0});
    lowch  = bl3_q ? IW'(ch_q[2:0]) : IW'(ch_q[1:0]);
    plain_idx = plain_base_q + chp_q + IW'(k_q);
    blk_idx   = blk_base_q + blkp_q + kbl + lowch;
    if (pad) plain_idx = '0;
    res_d.source_index = to_blk_q ? plain_idx : blk_idx;
    res_d.dest_index   = to_blk_q ? blk_idx : plain_idx;
    res_d.value_out    = conv;
    res_d.is_padding   = pad;
    res_d.is_last      = lastp;
  end

  bclc_value_conv u_conv (
    .mode_i  (mode_q),
    .pad_i   (pad),
    .value_i (in_if.data),
    .value_o (conv)
  );

  // blocked chunk step: after the last channel of a block, add P*B
  logic blk_wrap;
  logic [IW-1:0] pb;
  assign blk_wrap = bl3_q ? (ch_q[2:0] == 3'd7) : (ch_q[1:0] == 2'd3);
  assign pb       = bl3_q ? IW'({p_q, 3'd0}) : IW'({p_q, 2'd0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      b_q <= '0; ch_q <= '0; k_q <= '0;
      plain_base_q <= '0; blk_base_q <= '0; chp_q <= '0; blkp_q <= '0;
    end else begin
      if (in_acc) out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
      if (cfg_wr || (in_acc && lastp)) begin
        b_q <= '0; ch_q <= '0; k_q <= '0;
        plain_base_q <= '0; blk_base_q <= '0; chp_q <= '0; blkp_q <= '0;
      end else if (in_acc) begin
        if (!k_end) begin
          k_q <= k_q + PW'(1);
        end else if (!ch_end) begin
          k_q   <= '0;
          ch_q  <= ch_q + CW'(1);
          chp_q <= chp_q + IW'(p_q);
          if (blk_wrap) blkp_q <= blkp_q + pb;
        end else begin
          k_q <= '0; ch_q <= '0; chp_q <= '0; blkp_q <= '0;
          b_q <= b_q + BW'(1);
          plain_base_q <= plain_base_q + cstr_q;
          blk_base_q   <= blk_base_q + cpstr_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) res_q <= res_d;
  end
endmodule

// File: sv/bclc_value_conv.sv
module bclc_value_conv
  import bclc_pkg::*;
(
  input  logic [1:0]  mode_i,
  input  logic        pad_i,
  input  logic [31:0] value_i,
  output logic [31:0] value_o
);
  // format conversion, zero on padding
  always_comb begin
    case (mode_i)
      MODE_WIDEN:  value_o = widen_half(value_i[15:0]);
      MODE_NARROW: value_o = narrow_single(value_i);
      default:     value_o = value_i;
    endcase
    if (pad_i) value_o = '0;
  end
endmodule

// File: verif/tb.sv
module tb;
  import bclc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned IDX_MASK = (64'd1 << 40) - 1;
  localparam longint unsigned N_MAX = 1024;
  localparam longint unsigned C_MAX = 65536;
  localparam longint unsigned P_MAX = 16777216;

  typedef struct packed {
    logic [39:0] source_index;
    logic [39:0] dest_index;
    logic [31:0] value_out;
    logic        is_padding;
    logic        is_last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  bclc_cfg_if                         cfg_if ();
  bclc_stream_if #(.T(logic [31:0]))  in_if ();
  bclc_stream_if #(.T(result_t))      out_if ();

  blocked_channel_layout_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // clock and reset
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // shadow registers and loop position
  logic        sh_to_blocked;
  logic [1:0]  sh_block_log;
  logic [1:0]  sh_mode;
  logic [10:0] sh_batch;
  logic [16:0] sh_channels;
  logic [24:0] sh_plane;
  longint unsigned pos_b, pos_ch, pos_p, base_plain, base_blk;

  logic [31:0] pending_values[$];
  result_t     expected_results[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [31:0] s;
    logic [4:0]  e;
    logic [10:0] m;
    logic [7:0]  ex;
    s = {h[15], 31'd0};
    e = h[14:10];
    m = {1'b0, h[9:0]};
    if (e == 5'd31)
      return (m != 0) ? (s | 32'h7FC0_0000 | (32'(m) << 13)) : (s | 32'h7F80_0000);
    if (e == 5'd0) begin
      if (m == 0) return s;
      ex = 8'd113;
      while (!m[10]) begin
        m  = m << 1;
        ex = ex - 8'd1;
      end
      return s | (32'(ex) << 23) | (32'(m[9:0]) << 13);
    end
    return s | ((32'(e) + 32'd112) << 23) | (32'(m) << 13);
  endfunction

  function automatic logic [31:0] single_to_half(logic [31:0] x);
    logic [31:0] s, m, h, rem, halfway, full;
    int e, e16, sh;
    s = (x >> 16) & 32'h8000;
    e = int'(x[30:23]);
    m = x & 32'h7F_FFFF;
    if (e == 255) return m != 0 ? (s | 32'h7E00 | (m >> 13)) : (s | 32'h7C00);
    e16 = e - 112;
    if (e16 >= 31) return s | 32'h7C00;
    if (e16 >= 1) begin
      h   = (32'(e16) << 10) | (m >> 13);
      rem = m & 32'h1FFF;
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
      return s | h;
    end
    if (e16 < -10 || e == 0) return s;
    full    = m | 32'h80_0000;
    sh      = 14 - e16;
    h       = full >> sh;
    rem     = full & ((32'd1 << sh) - 1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && h[0])) h++;
    return s | h;
  endfunction

  function automatic longint unsigned clamp(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    return v > hi ? hi : v;
  endfunction

  function automatic void restart_tensor();
    pos_b = 0; pos_ch = 0; pos_p = 0; base_plain = 0; base_blk = 0;
  endfunction

  // expected result of one element; advances the loop position
  function automatic result_t convert_element(logic [31:0] vin);
    result_t r;
    int unsigned bl;
    longint unsigned bsz, n, c, p, cp, lim, pi, bi;
    logic [31:0] v;
    logic pad;
    bl  = sh_block_log < 2 ? 2 : sh_block_log;
    bsz = 64'd1 << bl;
    n   = clamp(sh_batch, N_MAX);
    c   = clamp(sh_channels, C_MAX);
    p   = clamp(sh_plane, P_MAX);
    cp  = (c + bsz - 1) & ~(bsz - 1);
    lim = sh_to_blocked ? cp : c;
    pi  = (base_plain + pos_ch * p + pos_p) & IDX_MASK;
    bi  = (base_blk + (((pos_ch >> bl) * p) << bl) + (pos_p << bl) + (pos_ch & (bsz - 1)))
          & IDX_MASK;
    case (sh_mode)
      MODE_WIDEN:  v = half_to_single(vin[15:0]);
      MODE_NARROW: v = single_to_half(vin);
      default:     v = vin;
    endcase
    pad = sh_to_blocked && pos_ch >= c;
    if (pad) begin
      v  = 0;
      pi = 0;
    end
    r.source_index = sh_to_blocked ? pi[39:0] : bi[39:0];
    r.dest_index   = sh_to_blocked ? bi[39:0] : pi[39:0];
    r.value_out    = v;
    r.is_padding   = pad;
    r.is_last      = (pos_b + 1 >= n) && (pos_ch + 1 >= lim) && (pos_p + 1 >= p);
    if (pos_p + 1 < p) begin
      pos_p++;
    end else if (pos_ch + 1 < lim) begin
      pos_p = 0;
      pos_ch++;
    end else if (pos_b + 1 < n) begin
      pos_p = 0;
      pos_ch = 0;
      pos_b++;
      base_plain = (base_plain + c * p) & IDX_MASK;
      base_blk   = (base_blk + cp * p) & IDX_MASK;
    end else begin
      restart_tensor();
    end
    return r;
  endfunction

  // element driver; expectation formed at each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready)
        expected_results.push_back(convert_element(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (pending_values.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= pending_values.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || $urandom_range(99) >= 14;
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got.source_index !== want.source_index || got.dest_index !== want.dest_index ||
              got.value_out !== want.value_out || got.is_padding !== want.is_padding ||
              got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: src %h/%h dst %h/%h val %h/%h pad %b/%b last %b/%b (exp/act)",
                       want.source_index, got.source_index, want.dest_index, got.dest_index,
                       want.value_out, got.value_out, want.is_padding, got.is_padding,
                       want.is_last, got.is_last);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_values.size() > 0 || expected_results.size() > 0 || in_if.valid)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // one register write; valid is left high so writes can follow back to back
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_TO_BLOCKED:    sh_to_blocked = val[0];
      REG_BLOCK_LOG:     sh_block_log  = val[1:0];
      REG_VALUE_MODE:    sh_mode       = val[1:0];
      REG_BATCH_COUNT:   sh_batch      = val[10:0];
      REG_CHANNEL_COUNT: sh_channels   = val[16:0];
      REG_PLANE_SIZE:    sh_plane      = val[24:0];
      default: ;
    endcase
    restart_tensor();
  endtask

  task automatic setup(logic [31:0] dir, logic [31:0] blog, logic [31:0] mode,
                       logic [31:0] n, logic [31:0] c, logic [31:0] p);
    wait_drained();
    write_reg(REG_TO_BLOCKED, dir);
    write_reg(REG_BLOCK_LOG, blog);
    write_reg(REG_VALUE_MODE, mode);
    write_reg(REG_BATCH_COUNT, n);
    write_reg(REG_CHANNEL_COUNT, c);
    write_reg(REG_PLANE_SIZE, p);
    cfg_if.valid <= 1'b0;
  endtask

  logic [31:0] float_corners[$] = '{
    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_1234, 32'h477F_F000, 32'h477F_E000,
    32'h3300_0000, 32'h3300_0001, 32'h387F_C000, 32'h0000_0001, 32'h8000_0000,
    32'h3F80_1000, 32'h3F80_3000, 32'hFFFF_FFFF
  };
  logic [31:0] half_corners[$] = '{
    32'h0001, 32'h03FF, 32'h7C00, 32'hFC00, 32'h7E01, 32'h8000, 32'h3C00, 32'h7BFF
  };

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return float_corners[$urandom_range(float_corners.size() - 1)] ^ $urandom_range(1);
      1: return $urandom_range(32'hFFFF);
      default: return $urandom();
    endcase
  endfunction

  // stimulus
  initial begin
    int total, cnt;
    sh_to_blocked = 1'b1; sh_block_log = 2'd3; sh_mode = MODE_COPY;
    sh_batch = 11'd1; sh_channels = 17'd8; sh_plane = 25'd1;
    restart_tensor();
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.wdata = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // defaults, crossing the tensor end
    repeat (10) pending_values.push_back($urandom());
    // narrowing corners, blocked to plain
    setup(0, 2, MODE_NARROW, 1, 3, 5);
    foreach (float_corners[i]) pending_values.push_back(float_corners[i]);
    // widening corners with padding
    setup(1, 2, MODE_WIDEN, 2, 1, 1);
    foreach (half_corners[i]) pending_values.push_back(half_corners[i]);
    // zero counts, low block log, unused mode
    setup(1, 0, 3, 0, 0, 0);
    repeat (5) pending_values.push_back($urandom());
    // counts above maximum
    setup(0, 1, MODE_COPY, 32'h7FF, 32'h1FFFF, 32'h1FF_FFFF);
    repeat (6) pending_values.push_back($urandom());

    total = 0;
    while (total < 1250) begin
      if ($urandom_range(7) == 0)
        setup($urandom_range(1), $urandom_range(3), $urandom_range(3), $urandom(),
              $urandom(), $urandom());
      else
        setup($urandom_range(1), $urandom_range(3), $urandom_range(3), $urandom_range(3),
              $urandom_range(20), $urandom_range(6));
      // a long stretch without idling on either side
      calm = (total >= 400 && total < 700) || ($urandom_range(9) == 0);
      cnt = $urandom_range(60, 5);
      repeat (cnt) pending_values.push_back(rand_value());
      total += cnt;
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/bclc_pkg.sv
sv/bclc_stream_if.sv
sv/bclc_cfg_if.sv
sv/bclc_value_conv.sv
sv/blocked_channel_layout_converter.sv
verif/tb.sv
